>>> src/form_field_extract_decode_defines.svh
// assertion macros for the form field extractor, used by the result register
`ifndef FORM_FIELD_EXTRACT_DECODE_DEFINES_SVH
`define FORM_FIELD_EXTRACT_DECODE_DEFINES_SVH
`ifndef SYNTHESIS
// plain property checked on every rising clock edge out of reset
`define FFX_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// same-cycle implication
`define FFX_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define FFX_ASSERT(label, prop, msg)
`define FFX_ASSERT_IMPL(label, ante, cons, msg)
`endif
`endif

>>> src/ffx_pkg.sv
// shared types, constants and helpers for the form field extractor
`default_nettype none
package ffx_pkg;

    localparam int NAME_BYTES = 8;
    localparam int NAME_W     = 8 * NAME_BYTES;
    localparam int MAX_EMIT   = 3;

    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_EQ      = 8'h3D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_NUL     = 8'h00;

    // configuration register indexes
    localparam logic [1:0] CFG_FIELD_NAME  = 2'd0;
    localparam logic [1:0] CFG_NAME_LENGTH = 2'd1;
    localparam logic [1:0] CFG_VALUE_LIMIT = 2'd2;

    localparam logic [63:0] RST_FIELD_NAME  = 64'h0;
    localparam logic [3:0]  RST_NAME_LENGTH = 4'd4;
    localparam logic [7:0]  RST_VALUE_LIMIT = 8'd32;

    typedef enum logic [1:0] {
        PH_MATCH = 2'd0,
        PH_SKIP  = 2'd1,
        PH_VALUE = 2'd2,
        PH_DONE  = 2'd3
    } phase_t;

    // up to three decoded bytes produced by one item
    typedef struct packed {
        logic [1:0]                  cnt;
        logic [MAX_EMIT-1:0][7:0]    data;
    } emit_list_t;

    // everything one body byte produces
    typedef struct packed {
        emit_list_t el;
        logic       found;
        logic       done;
    } step_res_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       run_last;
    } out_entry_t;

    function automatic emit_list_t emit_push(emit_list_t l, logic [7:0] v);
        emit_list_t r;
        r = l;
        if (l.cnt != 2'(MAX_EMIT))
        begin
            r.data[l.cnt] = v;
            r.cnt         = l.cnt + 2'd1;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

>>> src/ffx_parse.sv
// per-byte parser: key match, value window and url decode in one pass
`default_nettype none
module ffx_parse (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic [ffx_pkg::NAME_W-1:0] field_name,
    input  wire logic [3:0]                name_length,
    input  wire logic [7:0]                value_limit,
    input  wire logic [7:0]                body_byte,
    input  wire logic                      body_end,
    input  wire logic                      load,
    output ffx_pkg::step_res_t             res
);
    import ffx_pkg::*;

    typedef struct packed {
        logic [1:0] pc;
        logic [7:0] pd;
        emit_list_t el;
    } dec_t;

    phase_t     phase_reg, phase_next, phase_step;
    logic [3:0] kp_reg, kp_next, kp_step;
    logic [7:0] rc_reg, rc_next, rc_step;
    logic [1:0] pc_reg, pc_next;
    logic [7:0] pd_reg, pd_next;
    logic       found_reg, found_next, found_step;
    logic [3:0] name_len;
    logic       ended;
    dec_t       dec;

    function automatic logic is_hex(logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function automatic logic [3:0] hex_val(logic [7:0] c);
        logic [7:0] v;
        if (c >= "0" && c <= "9")
            v = c - "0";
        else if (c >= "a" && c <= "f")
            v = c - "a" + 8'd10;
        else if (c >= "A" && c <= "F")
            v = c - "A" + 8'd10;
        else
            v = 8'h00;
        return v[3:0];
    endfunction

    function automatic dec_t dec_flush(dec_t d);
        dec_t r;
        r = d;
        if (d.pc != 2'd0)
            r.el = emit_push(r.el, CH_PERCENT);
        if (d.pc == 2'd2)
            r.el = emit_push(r.el, d.pd);
        r.pc = 2'd0;
        r.pd = CH_NUL;
        return r;
    endfunction

    function automatic dec_t dec_fresh(dec_t d, logic [7:0] b);
        dec_t r;
        r = d;
        if (b == CH_PERCENT)
            r.pc = 2'd1;
        else if (b == CH_PLUS)
            r.el = emit_push(r.el, CH_SPACE);
        else
            r.el = emit_push(r.el, b);
        return r;
    endfunction

    function automatic dec_t dec_byte(dec_t d, logic [7:0] b);
        dec_t r;
        r = d;
        priority if (d.pc == 2'd0)
        begin
            r = dec_fresh(d, b);
        end
        else if (d.pc == 2'd1)
        begin
            if (is_hex(b))
            begin
                r.pc = 2'd2;
                r.pd = b;
            end
            else
            begin
                r.pc = 2'd0;
                r.el = emit_push(r.el, CH_PERCENT);
                r    = dec_fresh(r, b);
            end
        end
        else
        begin
            if (is_hex(b))
            begin
                r.el = emit_push(r.el, {hex_val(d.pd), hex_val(b)});
                r.pc = 2'd0;
                r.pd = CH_NUL;
            end
            else
            begin
                r = dec_flush(d);
                r = dec_fresh(r, b);
            end
        end
        return r;
    endfunction

    assign name_len = (name_length > 4'(NAME_BYTES)) ? 4'(NAME_BYTES) : name_length;
    assign ended    = (body_byte == CH_NUL) || body_end;

    // one byte through the parser
    always_comb
    begin
        phase_step = phase_reg;
        kp_step    = kp_reg;
        rc_step    = rc_reg;
        found_step = found_reg;
        dec.pc     = pc_reg;
        dec.pd     = pd_reg;
        dec.el     = '0;
        if (body_byte != CH_NUL)
        begin
            unique case (phase_reg)
                PH_MATCH:
                begin
                    if (body_byte == CH_AMP)
                    begin
                        kp_step = 4'd0;
                    end
                    else if (body_byte == CH_EQ)
                    begin
                        if (kp_reg == name_len)
                        begin
                            found_step = 1'b1;
                            rc_step    = 8'd0;
                            dec.pc     = 2'd0;
                            dec.pd     = CH_NUL;
                            phase_step = (value_limit == 8'd0) ? PH_DONE : PH_VALUE;
                        end
                        else
                        begin
                            phase_step = PH_SKIP;
                        end
                    end
                    else if (kp_reg < name_len && kp_reg < 4'(NAME_BYTES) &&
                             body_byte == field_name[{kp_reg[2:0], 3'b000} +: 8])
                    begin
                        kp_step = kp_reg + 4'd1;
                    end
                    else
                    begin
                        phase_step = PH_SKIP;
                    end
                end
                PH_SKIP:
                begin
                    if (body_byte == CH_AMP)
                    begin
                        phase_step = PH_MATCH;
                        kp_step    = 4'd0;
                    end
                end
                PH_VALUE:
                begin
                    if (body_byte == CH_AMP)
                    begin
                        dec        = dec_flush(dec);
                        phase_step = PH_DONE;
                    end
                    else
                    begin
                        rc_step = rc_reg + 8'd1;
                        dec     = dec_byte(dec, body_byte);
                        // last kept byte closes the value
                        if (rc_step >= value_limit)
                        begin
                            dec        = dec_flush(dec);
                            phase_step = PH_DONE;
                        end
                    end
                end
                PH_DONE:
                begin
                end
                default:
                begin
                end
            endcase
        end
        if (ended && phase_step == PH_VALUE)
        begin
            dec        = dec_flush(dec);
            phase_step = PH_DONE;
        end
    end

    // end of body returns the parser to its reset state
    always_comb
    begin
        if (ended)
        begin
            phase_next = PH_MATCH;
            kp_next    = 4'd0;
            rc_next    = 8'd0;
            pc_next    = 2'd0;
            pd_next    = CH_NUL;
            found_next = 1'b0;
        end
        else
        begin
            phase_next = phase_step;
            kp_next    = kp_step;
            rc_next    = rc_step;
            pc_next    = dec.pc;
            pd_next    = dec.pd;
            found_next = found_step;
        end
    end

    always_comb
    begin
        res.el    = dec.el;
        res.found = found_step;
        res.done  = (phase_step == PH_DONE) || ended;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_MATCH;
            kp_reg    <= 4'd0;
            rc_reg    <= 8'd0;
            pc_reg    <= 2'd0;
            pd_reg    <= CH_NUL;
            found_reg <= 1'b0;
        end
        else if (load)
        begin
            phase_reg <= phase_next;
            kp_reg    <= kp_next;
            rc_reg    <= rc_next;
            pc_reg    <= pc_next;
            pd_reg    <= pd_next;
            found_reg <= found_next;
        end
    end

endmodule
`default_nettype wire

>>> src/ffx_outbuf.sv
// result register: holds the one to three results of an item and drains them
`default_nettype none
`include "form_field_extract_decode_defines.svh"
module ffx_outbuf (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire ffx_pkg::step_res_t res,
    input  wire logic          in_valid,
    output logic               in_ready,
    output logic               load,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [7:0]         out_byte,
    output logic               byte_valid,
    output logic               field_found,
    output logic               run_last,
    output logic               body_done
);
    import ffx_pkg::*;

    out_entry_t                slot_reg [MAX_EMIT];
    out_entry_t                slot_next [MAX_EMIT];
    logic [1:0]                cnt_reg, cnt_next;
    logic                      found_reg, done_reg;
    logic [1:0]                n_res;
    logic                      out_fire;

    assign out_fire = out_valid && out_ready;
    // take a new item once the last held result leaves
    assign in_ready = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && out_ready);
    assign load     = in_valid && in_ready;
    assign n_res    = (res.el.cnt == 2'd0) ? 2'd1 : res.el.cnt;

    always_comb
    begin
        for (int k = 0; k < MAX_EMIT; k++)
        begin
            slot_next[k].byte_valid = 2'(k) < res.el.cnt;
            slot_next[k].out_byte   = (2'(k) < res.el.cnt) ? res.el.data[k] : 8'h00;
            slot_next[k].run_last   = 2'(k) == n_res - 2'd1;
        end
    end

    always_comb
    begin
        if (load)
            cnt_next = n_res;
        else if (out_fire)
            cnt_next = cnt_reg - 2'd1;
        else
            cnt_next = cnt_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int k = 0; k < MAX_EMIT; k++)
                slot_reg[k] <= slot_next[k];
            found_reg <= res.found;
            done_reg  <= res.done;
        end
        else if (out_fire)
        begin
            for (int k = 0; k < MAX_EMIT - 1; k++)
                slot_reg[k] <= slot_reg[k+1];
        end
    end

    assign out_valid   = cnt_reg != 2'd0;
    assign out_byte    = slot_reg[0].out_byte;
    assign byte_valid  = slot_reg[0].byte_valid;
    assign run_last    = slot_reg[0].run_last;
    assign field_found = found_reg;
    assign body_done   = done_reg;

    `FFX_ASSERT_IMPL(a_last_matches_count, out_valid,
        slot_reg[0].run_last == (cnt_reg == 2'd1), "run_last out of step with held count")
    `FFX_ASSERT_IMPL(a_status_alone, out_valid && !byte_valid, run_last,
        "status result followed by more results")
    `FFX_ASSERT(a_item_flags_hold,
        out_fire && !run_last |=> $stable(field_found) && $stable(body_done),
        "found or done changed inside one item")

endmodule
`default_nettype wire

>>> src/form_field_extract_decode.sv
// top level of the urlencoded form field extractor
//
// body bytes enter on the in channel (body_byte, body_end), one per item.
// each item gives one to three results on the out channel: decoded value
// bytes of the first pair whose key equals field_name, or a single status
// result with byte_valid low. run_last marks the final result of an item.
// field_found and body_done repeat on every result of the item.
// a zero byte or body_end closes the body and clears the parse state.
// configuration: cfg_index selects field_name, name_length or value_limit;
// cfg_ready is always high; the user must write only while the block is
// idle, the block itself does not enforce it. a taken item's first result
// is registered and shown in the next cycle. throughput: one item per
// cycle while each item gives one result and out_ready is high; an item
// giving more results holds the out channel, and in_ready drops until its
// last result is leaving. on a stall, results hold in the result register
// and in_ready stays low. reset returns the parser to key matching and the
// registers to field_name 0, name_length 4, value_limit 32.
`default_nettype none
module form_field_extract_decode (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  body_byte,
    input  wire logic        body_end,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       out_byte,
    output logic             byte_valid,
    output logic             field_found,
    output logic             run_last,
    output logic             body_done,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [63:0] cfg_data
);
    import ffx_pkg::*;

    logic [NAME_W-1:0] field_name_reg;
    logic [3:0]        name_length_reg;
    logic [7:0]        value_limit_reg;
    step_res_t         res;
    logic              load;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_name_reg  <= RST_FIELD_NAME;
            name_length_reg <= RST_NAME_LENGTH;
            value_limit_reg <= RST_VALUE_LIMIT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_FIELD_NAME:  field_name_reg  <= cfg_data[NAME_W-1:0];
                CFG_NAME_LENGTH: name_length_reg <= cfg_data[3:0];
                CFG_VALUE_LIMIT: value_limit_reg <= cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    ffx_parse u_parse (
        .clk         (clk),
        .rst_n       (rst_n),
        .field_name  (field_name_reg),
        .name_length (name_length_reg),
        .value_limit (value_limit_reg),
        .body_byte   (body_byte),
        .body_end    (body_end),
        .load        (load),
        .res         (res)
    );

    ffx_outbuf u_outbuf (
        .clk         (clk),
        .rst_n       (rst_n),
        .res         (res),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .load        (load),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .byte_valid  (byte_valid),
        .field_found (field_found),
        .run_last    (run_last),
        .body_done   (body_done)
    );

endmodule
`default_nettype wire
